// ===== design/wrpe_pkg.sv =====
package wrpe_pkg;

    localparam int MAX_NODES  = 512;
    localparam int MAX_STEPS  = 3;
    localparam int COLS       = MAX_STEPS + 1;
    localparam int COL_W      = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int LOG_CELLS  = 5;
    localparam int NUM_CELLS  = 1 << LOG_CELLS;
    localparam int CELL_DEPTH = (MAX_NODES + NUM_CELLS - 1) / NUM_CELLS;
    localparam int SLOT_W     = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
    localparam int TAG_W      = SLOT_W + LOG_CELLS;
    localparam int ADDR_W     = $clog2(MAX_NODES);
    localparam int TOTAL_W    = $clog2(MAX_NODES + 1);
    localparam int NODE_W     = 31;
    localparam int STEP_W     = 2;
    localparam int SEL_W      = 9;
    localparam int COUNT_W    = 11;
    localparam int SIZE_W     = 10;
    localparam int WALK_RESET = 100;

    typedef logic [NODE_W-1:0]    node_t;
    typedef logic [STEP_W-1:0]    step_t;
    typedef logic [SEL_W-1:0]     sel_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [SIZE_W-1:0]    size_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [TOTAL_W-1:0]   total_t;
    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [LOG_CELLS-1:0] cell_id_t;
    typedef logic [TAG_W-1:0]     tag_t;
    typedef logic [COL_W-1:0]     col_t;
    typedef logic [COLS-1:0][COUNT_W-1:0] count_row_t;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_TOKEN = 2'd1,
        REQ_READ  = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SEARCH,
        ST_FETCH,
        ST_UPDATE,
        ST_RESPOND
    } state_t;

    typedef struct packed {
        logic  valid;
        logic  last;
        slot_t slot;
        logic  found;
        tag_t  tag;
    } wave_t;

    typedef struct packed {
        logic     en;
        cell_id_t target;
        slot_t    slot;
        node_t    data;
    } cell_wr_t;

    typedef struct packed {
        logic       en;
        addr_t      addr;
        count_row_t data;
    } cnt_wr_t;

endpackage

// ===== design/wrpe_cell.sv =====
module wrpe_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  wrpe_pkg::cell_id_t  cell_id,
    input  wrpe_pkg::node_t     key,
    input  wrpe_pkg::total_t    limit,
    input  wrpe_pkg::wave_t     wave_in,
    output wrpe_pkg::wave_t     wave_out,
    input  wrpe_pkg::cell_wr_t  wr,
    input  wrpe_pkg::slot_t     rd_slot,
    output wrpe_pkg::node_t     rd_data
);

    wrpe_pkg::node_t ids_reg [wrpe_pkg::CELL_DEPTH];
    wrpe_pkg::wave_t wave_reg;
    wrpe_pkg::wave_t wave_next;
    wrpe_pkg::slot_t rd_addr;
    wrpe_pkg::tag_t  tag;
    logic            in_use;
    logic            match;

    // Row number of the entry under test is slot * NUM_CELLS + cell_id.
    always_comb
    begin
        rd_addr   = wave_in.valid ? wave_in.slot : rd_slot;
        tag       = {wave_in.slot, cell_id};
        in_use    = (wrpe_pkg::total_t'(tag) < limit);
        match     = wave_in.valid && in_use && (ids_reg[rd_addr] == key);
        wave_next = wave_in;
        if (match)
        begin
            wave_next.found = 1'b1;
            wave_next.tag   = tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg <= '0;
        end
        else
        begin
            wave_reg <= wave_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.target == cell_id))
        begin
            ids_reg[wr.slot] <= wr.data;
        end
    end

    assign wave_out = wave_reg;
    assign rd_data  = ids_reg[rd_addr];

endmodule

// ===== design/wrpe_count_store.sv =====
module wrpe_count_store (
    input  logic                  clk,
    input  wrpe_pkg::cnt_wr_t     wr,
    input  logic                  rd_en,
    input  wrpe_pkg::addr_t       rd_addr,
    output wrpe_pkg::count_row_t  rd_data
);

    wrpe_pkg::count_row_t mem_reg [wrpe_pkg::MAX_NODES];
    wrpe_pkg::count_row_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/walk_relative_position_encoder_top.sv =====
// Relative position encoder for the walks from one root. Requests are taken one at a time;
// a start, a rejected request or a token on an empty table goes from dispatch straight to
// the response, a valid read passes through fetch and update first, and any other token
// searches before it goes to fetch and update on a hit or to the response on a miss:
// node ids live in a chain of 32 registered cells, each holding every 32nd row, and a
// search wave per slot ripples through all cells before the hit or miss is known. The next
// request can be accepted once the result is in the output register. A hit then reads and
// rewrites the row's step counts in one memory row per node. A new node's counts are written
// whole when its row is taken, so a start needs no clearing pass. Rows at or beyond set_size
// read as not valid. The result sits in an output register, and the next request is accepted
// while it waits.
module walk_relative_position_encoder_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  wrpe_pkg::count_t      cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            req_type,
    input  wrpe_pkg::node_t       node_id,
    input  wrpe_pkg::step_t       step_index,
    input  wrpe_pkg::sel_t        row_select,
    output logic                  out_valid,
    input  logic                  out_ready,
    output wrpe_pkg::sel_t        row_index,
    output logic                  is_new,
    output wrpe_pkg::node_t       row_node,
    output wrpe_pkg::count_t      step_count,
    output wrpe_pkg::size_t       set_size,
    output logic [1:0]            status
);

    wrpe_pkg::state_t   state_reg, state_next;
    wrpe_pkg::count_t   walk_count_reg, walk_count_next;
    wrpe_pkg::total_t   unique_reg, unique_next;
    logic [1:0]         req_reg, req_next;
    wrpe_pkg::node_t    node_reg, node_next;
    wrpe_pkg::step_t    step_reg, step_next;
    wrpe_pkg::sel_t     sel_reg, sel_next;
    wrpe_pkg::addr_t    row_reg, row_next;
    wrpe_pkg::slot_t    issue_slot_reg, issue_slot_next;
    logic               issue_done_reg, issue_done_next;
    logic               found_reg, found_next;
    wrpe_pkg::tag_t     found_tag_reg, found_tag_next;

    wrpe_pkg::sel_t     res_row_reg, res_row_next;
    logic               res_new_reg, res_new_next;
    wrpe_pkg::node_t    res_node_reg, res_node_next;
    wrpe_pkg::count_t   res_count_reg, res_count_next;
    wrpe_pkg::status_t  res_status_reg, res_status_next;

    logic               out_valid_reg, out_valid_next;
    wrpe_pkg::sel_t     out_row_reg, out_row_next;
    logic               out_new_reg, out_new_next;
    wrpe_pkg::node_t    out_node_reg, out_node_next;
    wrpe_pkg::count_t   out_count_reg, out_count_next;
    wrpe_pkg::size_t    out_size_reg, out_size_next;
    wrpe_pkg::status_t  out_status_reg, out_status_next;

    wrpe_pkg::wave_t    waves [wrpe_pkg::NUM_CELLS + 1];
    wrpe_pkg::node_t    cell_rd [wrpe_pkg::NUM_CELLS];
    wrpe_pkg::cell_wr_t cell_wr;
    wrpe_pkg::slot_t    rd_slot;
    wrpe_pkg::cnt_wr_t  cnt_wr;
    logic               cnt_rd_en;
    wrpe_pkg::count_row_t cnt_rd_data;

    wrpe_pkg::wave_t    tail;
    wrpe_pkg::slot_t    last_slot;
    wrpe_pkg::col_t     col;
    logic               tail_done;
    logic               hit;
    wrpe_pkg::tag_t     hit_tag;
    logic               table_full;
    logic               step_ok;
    logic               read_ok;
    logic               out_free;

    assign tail       = waves[wrpe_pkg::NUM_CELLS];
    assign last_slot  = wrpe_pkg::slot_t'((unique_reg - wrpe_pkg::total_t'(1))
                                          >> wrpe_pkg::LOG_CELLS);
    assign col        = wrpe_pkg::col_t'(step_reg);
    assign tail_done  = tail.valid && tail.last;
    assign hit        = found_reg || tail.found;
    assign hit_tag    = tail.found ? tail.tag : found_tag_reg;
    assign table_full = (unique_reg >= wrpe_pkg::total_t'(wrpe_pkg::MAX_NODES));
    assign step_ok    = (step_reg != '0) && (step_reg <= wrpe_pkg::MAX_STEPS);
    assign read_ok    = (wrpe_pkg::total_t'(sel_reg) < unique_reg)
                        && (sel_reg < wrpe_pkg::MAX_NODES)
                        && (step_reg <= wrpe_pkg::MAX_STEPS);
    assign out_free   = !out_valid_reg || out_ready;
    assign rd_slot    = wrpe_pkg::slot_t'(row_reg >> wrpe_pkg::LOG_CELLS);

    assign waves[0].valid = (state_reg == wrpe_pkg::ST_SEARCH) && !issue_done_reg;
    assign waves[0].last  = (issue_slot_reg == last_slot);
    assign waves[0].slot  = issue_slot_reg;
    assign waves[0].found = 1'b0;
    assign waves[0].tag   = '0;

    for (genvar i = 0; i < wrpe_pkg::NUM_CELLS; i++)
    begin : g_cell
        wrpe_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_id  (wrpe_pkg::cell_id_t'(i)),
            .key      (node_reg),
            .limit    (unique_reg),
            .wave_in  (waves[i]),
            .wave_out (waves[i + 1]),
            .wr       (cell_wr),
            .rd_slot  (rd_slot),
            .rd_data  (cell_rd[i])
        );
    end

    wrpe_count_store u_counts (
        .clk     (clk),
        .wr      (cnt_wr),
        .rd_en   (cnt_rd_en),
        .rd_addr (row_reg),
        .rd_data (cnt_rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wrpe_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = wrpe_pkg::ST_DISPATCH;
                end
            end
            wrpe_pkg::ST_DISPATCH:
            begin
                case (req_reg)
                    wrpe_pkg::REQ_TOKEN:
                    begin
                        if (step_ok && (unique_reg != '0))
                        begin
                            state_next = wrpe_pkg::ST_SEARCH;
                        end
                        else
                        begin
                            state_next = wrpe_pkg::ST_RESPOND;
                        end
                    end
                    wrpe_pkg::REQ_READ:
                    begin
                        state_next = read_ok ? wrpe_pkg::ST_FETCH : wrpe_pkg::ST_RESPOND;
                    end
                    default:
                    begin
                        state_next = wrpe_pkg::ST_RESPOND;
                    end
                endcase
            end
            wrpe_pkg::ST_SEARCH:
            begin
                if (tail_done)
                begin
                    state_next = hit ? wrpe_pkg::ST_FETCH : wrpe_pkg::ST_RESPOND;
                end
            end
            wrpe_pkg::ST_FETCH:
            begin
                state_next = wrpe_pkg::ST_UPDATE;
            end
            wrpe_pkg::ST_UPDATE:
            begin
                state_next = wrpe_pkg::ST_RESPOND;
            end
            wrpe_pkg::ST_RESPOND:
            begin
                if (out_free)
                begin
                    state_next = wrpe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wrpe_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        logic                 alloc;
        wrpe_pkg::count_row_t start_row;
        wrpe_pkg::count_row_t alloc_row;
        wrpe_pkg::count_row_t upd_row;
        wrpe_pkg::count_t     cval;

        alloc           = 1'b0;
        start_row       = '0;
        start_row[0]    = walk_count_reg;
        alloc_row       = '0;
        alloc_row[col]  = wrpe_pkg::count_t'(1);
        upd_row         = cnt_rd_data;
        cval            = cnt_rd_data[col];
        if (cval != '1)
        begin
            cval = cval + wrpe_pkg::count_t'(1);
        end
        upd_row[col]    = cval;

        walk_count_next = cfg_we ? cfg_wdata : walk_count_reg;
        unique_next     = unique_reg;
        req_next        = req_reg;
        node_next       = node_reg;
        step_next       = step_reg;
        sel_next        = sel_reg;
        row_next        = row_reg;
        issue_slot_next = issue_slot_reg;
        issue_done_next = issue_done_reg;
        found_next      = found_reg;
        found_tag_next  = found_tag_reg;
        res_row_next    = res_row_reg;
        res_new_next    = res_new_reg;
        res_node_next   = res_node_reg;
        res_count_next  = res_count_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_row_next    = out_row_reg;
        out_new_next    = out_new_reg;
        out_node_next   = out_node_reg;
        out_count_next  = out_count_reg;
        out_size_next   = out_size_reg;
        out_status_next = out_status_reg;
        cell_wr         = '0;
        cnt_wr          = '0;
        cnt_rd_en       = 1'b0;

        case (state_reg)
            wrpe_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next  = req_type;
                    node_next = node_id;
                    step_next = step_index;
                    sel_next  = row_select;
                end
            end
            wrpe_pkg::ST_DISPATCH:
            begin
                res_row_next    = '0;
                res_new_next    = 1'b0;
                res_node_next   = '0;
                res_count_next  = '0;
                res_status_next = wrpe_pkg::STATUS_INVALID;
                case (req_reg)
                    wrpe_pkg::REQ_START:
                    begin
                        cell_wr.en      = 1'b1;
                        cell_wr.target  = '0;
                        cell_wr.slot    = '0;
                        cell_wr.data    = node_reg;
                        cnt_wr.en       = 1'b1;
                        cnt_wr.addr     = '0;
                        cnt_wr.data     = start_row;
                        unique_next     = wrpe_pkg::total_t'(1);
                        res_new_next    = 1'b1;
                        res_node_next   = node_reg;
                        res_count_next  = walk_count_reg;
                        res_status_next = wrpe_pkg::STATUS_OK;
                    end
                    wrpe_pkg::REQ_TOKEN:
                    begin
                        if (step_ok)
                        begin
                            if (unique_reg == '0)
                            begin
                                alloc = 1'b1;
                            end
                            else
                            begin
                                issue_slot_next = '0;
                                issue_done_next = 1'b0;
                                found_next      = 1'b0;
                            end
                        end
                    end
                    wrpe_pkg::REQ_READ:
                    begin
                        res_row_next = sel_reg;
                        row_next     = wrpe_pkg::addr_t'(sel_reg);
                    end
                    default:
                    begin
                    end
                endcase
            end
            wrpe_pkg::ST_SEARCH:
            begin
                if (!issue_done_reg)
                begin
                    issue_slot_next = issue_slot_reg + wrpe_pkg::slot_t'(1);
                    if (issue_slot_reg == last_slot)
                    begin
                        issue_done_next = 1'b1;
                    end
                end
                if (tail.valid && tail.found)
                begin
                    found_next     = 1'b1;
                    found_tag_next = tail.tag;
                end
                if (tail_done)
                begin
                    if (hit)
                    begin
                        row_next = wrpe_pkg::addr_t'(hit_tag);
                    end
                    else if (table_full)
                    begin
                        res_row_next    = '0;
                        res_new_next    = 1'b0;
                        res_node_next   = node_reg;
                        res_count_next  = '0;
                        res_status_next = wrpe_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        alloc = 1'b1;
                    end
                end
            end
            wrpe_pkg::ST_FETCH:
            begin
                cnt_rd_en = 1'b1;
            end
            wrpe_pkg::ST_UPDATE:
            begin
                res_new_next    = 1'b0;
                res_status_next = wrpe_pkg::STATUS_OK;
                if (req_reg == wrpe_pkg::REQ_TOKEN)
                begin
                    cnt_wr.en      = 1'b1;
                    cnt_wr.addr    = row_reg;
                    cnt_wr.data    = upd_row;
                    res_row_next   = wrpe_pkg::sel_t'(row_reg);
                    res_node_next  = node_reg;
                    res_count_next = cval;
                end
                else
                begin
                    res_row_next   = sel_reg;
                    res_node_next  = cell_rd[wrpe_pkg::cell_id_t'(row_reg)];
                    res_count_next = cnt_rd_data[col];
                end
            end
            wrpe_pkg::ST_RESPOND:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_row_next    = res_row_reg;
                    out_new_next    = res_new_reg;
                    out_node_next   = res_node_reg;
                    out_count_next  = res_count_reg;
                    out_size_next   = wrpe_pkg::size_t'(unique_reg);
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
            end
        endcase

        // A node seen for the first time takes the next free row with fresh counts.
        if (alloc)
        begin
            cell_wr.en      = 1'b1;
            cell_wr.target  = wrpe_pkg::cell_id_t'(unique_reg);
            cell_wr.slot    = wrpe_pkg::slot_t'(unique_reg >> wrpe_pkg::LOG_CELLS);
            cell_wr.data    = node_reg;
            cnt_wr.en       = 1'b1;
            cnt_wr.addr     = wrpe_pkg::addr_t'(unique_reg);
            cnt_wr.data     = alloc_row;
            unique_next     = unique_reg + wrpe_pkg::total_t'(1);
            res_row_next    = wrpe_pkg::sel_t'(unique_reg);
            res_new_next    = 1'b1;
            res_node_next   = node_reg;
            res_count_next  = wrpe_pkg::count_t'(1);
            res_status_next = wrpe_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= wrpe_pkg::ST_IDLE;
            walk_count_reg <= wrpe_pkg::count_t'(wrpe_pkg::WALK_RESET);
            unique_reg     <= '0;
            issue_done_reg <= 1'b1;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            walk_count_reg <= walk_count_next;
            unique_reg     <= unique_next;
            issue_done_reg <= issue_done_next;
            found_reg      <= found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        node_reg       <= node_next;
        step_reg       <= step_next;
        sel_reg        <= sel_next;
        row_reg        <= row_next;
        issue_slot_reg <= issue_slot_next;
        found_tag_reg  <= found_tag_next;
        res_row_reg    <= res_row_next;
        res_new_reg    <= res_new_next;
        res_node_reg   <= res_node_next;
        res_count_reg  <= res_count_next;
        res_status_reg <= res_status_next;
        out_row_reg    <= out_row_next;
        out_new_reg    <= out_new_next;
        out_node_reg   <= out_node_next;
        out_count_reg  <= out_count_next;
        out_size_reg   <= out_size_next;
        out_status_reg <= out_status_next;
    end

    assign in_ready   = (state_reg == wrpe_pkg::ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign row_index  = out_row_reg;
    assign is_new     = out_new_reg;
    assign row_node   = out_node_reg;
    assign step_count = out_count_reg;
    assign set_size   = out_size_reg;
    assign status     = out_status_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted twice in a row");

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        unique_reg <= wrpe_pkg::total_t'(wrpe_pkg::MAX_NODES))
        else $error("row count beyond table size");

    a_wave_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        waves[wrpe_pkg::NUM_CELLS].valid |-> state_reg == wrpe_pkg::ST_SEARCH)
        else $error("search wave left the chain outside a search");

    a_new_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_new |-> status == wrpe_pkg::STATUS_OK)
        else $error("new row reported with a failing status");

endmodule
